### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the encoder modules. They expand to nothing
// in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define HTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked during reset too
`define HTE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HTE_ASSERT(lbl, prop, msg)
`define HTE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### design/hte_pkg.sv
// ---------------------------------------------------------------------------
// hte_pkg
// Constants, request codes and controller/datapath interface types for the
// table-driven huffman encoder.
// ---------------------------------------------------------------------------
package hte_pkg;

    localparam int SYMBOLS      = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int REQ_W        = 2;
    localparam int TABLE_DEPTH  = 257;
    localparam int ADDR_W       = 9;
    localparam int ENTRY_W      = CODE_W + LEN_W;
    localparam int ACC_W        = 40;
    localparam int TOT_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int IN_DATA_W    = 48;
    localparam int IN_USER_W    = 2;
    localparam int OUT_USER_W   = 2;

    localparam logic [ADDR_W-1:0] EOS_ENTRY = 9'd256;
    localparam logic [LEN_W-1:0]  LEN_LIMIT =
        LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END    = 2'd2;

    typedef struct packed {
        logic capture;
        logic push;
        logic out_sel;
        logic out_bvalid;
        logic out_status;
        logic out_last;
        logic append;
        logic shift;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic have_byte;
        logic total_lt16;
        logic total_eq8;
        logic total_zero;
        logic out_free;
    } t_dp_stat;

endpackage

### design/hte_ram.sv
// ---------------------------------------------------------------------------
// hte_ram
// Generic single-write, single-read ram with registered read data.
// ---------------------------------------------------------------------------
module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/hte_datapath.sv
// ---------------------------------------------------------------------------
// hte_datapath
// Code table, bit accumulator and output register of the encoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [hte_pkg::IN_DATA_W-1:0]  i_data,
    input  logic [hte_pkg::REQ_W-1:0]      i_req,
    input  hte_pkg::t_dp_cmd               i_cmd,
    output hte_pkg::t_dp_stat              o_stat,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [hte_pkg::BYTE_W-1:0]     o_out_byte,
    output logic [hte_pkg::OUT_USER_W-1:0] o_out_user,
    output logic                           o_out_last
);
    import hte_pkg::*;

    logic [ADDR_W-1:0]      in_sym;
    logic [CODE_W-1:0]      in_bits;
    logic [LEN_W-1:0]       in_len;
    logic [LEN_W-1:0]       sat_len;
    logic                   wr_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ENTRY_W-1:0]     rd_entry;
    logic [CODE_W-1:0]      tbl_code;
    logic [LEN_W-1:0]       tbl_len;
    logic [CODE_W-1:0]      code_masked;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                   r_ent_vld;
    logic                   r_sym_ok;
    logic [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]       n_acc;
    logic [TOT_W-1:0]       r_total;
    logic [TOT_W-1:0]       n_total;
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;
    logic [OUT_USER_W-1:0]  r_out_user;
    logic                   r_out_last;
    logic                   out_free;

    assign in_sym  = i_data[ADDR_W-1:0];
    assign in_bits = i_data[ADDR_W+CODE_W-1:ADDR_W];
    assign in_len  = i_data[ADDR_W+CODE_W+LEN_W-1:ADDR_W+CODE_W];
    assign sat_len = (in_len > LEN_LIMIT) ? LEN_LIMIT : in_len;

    assign wr_en   = i_cmd.capture && (i_req == REQ_LOAD)
                     && ((in_sym < ADDR_W'(SYMBOLS)) || (in_sym == EOS_ENTRY));
    assign rd_addr = (i_req == REQ_END) ? EOS_ENTRY : in_sym;

    hte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (in_sym),
        .i_wdata ({sat_len, in_bits}),
        .i_re    (i_cmd.capture),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    assign tbl_code    = rd_entry[CODE_W-1:0];
    assign tbl_len     = rd_entry[ENTRY_W-1:CODE_W];
    assign code_masked = tbl_code & ~({CODE_W{1'b1}} << tbl_len);

    // length table reset: entries with no load read as no code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[in_sym] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ent_vld <= r_valid[rd_addr];
            r_sym_ok  <= (i_req == REQ_END) || (in_sym < ADDR_W'(SYMBOLS));
        end
    end

    always_comb begin
        n_acc   = r_acc;
        n_total = r_total;
        if (i_cmd.clear) begin
            n_acc   = '0;
            n_total = '0;
        end else if (i_cmd.append) begin
            n_acc   = r_acc | (ACC_W'(code_masked) << r_total);
            n_total = r_total + tbl_len;
        end else if (i_cmd.shift) begin
            n_acc   = r_acc >> BYTE_W;
            n_total = r_total - TOT_W'(BYTE_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_total <= '0;
        end else begin
            r_acc   <= n_acc;
            r_total <= n_total;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_byte <= i_cmd.out_sel ? r_acc[BYTE_W-1:0] : '0;
            r_out_user <= {i_cmd.out_status, i_cmd.out_bvalid};
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_stat.hit        = r_ent_vld && r_sym_ok && (tbl_len != '0);
    assign o_stat.have_byte  = r_total >= TOT_W'(BYTE_W);
    assign o_stat.total_lt16 = r_total < TOT_W'(2 * BYTE_W);
    assign o_stat.total_eq8  = r_total == TOT_W'(BYTE_W);
    assign o_stat.total_zero = r_total == '0;
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

    `HTE_ASSERT(a_push_when_free, i_cmd.push |-> out_free, "push into a full output register")
    `HTE_ASSERT(a_shift_has_byte, i_cmd.shift |-> (r_total >= TOT_W'(BYTE_W)),
                "shift without a full byte")
    `HTE_ASSERT(a_total_range, r_total <= TOT_W'(CODE_W + BYTE_W - 1),
                "bit count out of range")
    `HTE_ASSERT_RST(a_reset_out, !i_rst_n |=> !r_out_valid, "output valid after reset")

endmodule

### design/hte_ctrl.sv
// ---------------------------------------------------------------------------
// hte_ctrl
// Sequencer: accept, table lookup, then one result per cycle while the output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [hte_pkg::REQ_W-1:0] i_req,
    output logic                      o_in_ready,
    input  hte_pkg::t_dp_stat         i_stat,
    output hte_pkg::t_dp_cmd          o_cmd
);
    import hte_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [REQ_W-1:0] r_req;
    logic [REQ_W-1:0] n_req;
    logic             r_pack;
    logic             n_pack;
    logic             r_st;
    logic             n_st;
    logic             fin_last;
    t_dp_cmd          cmd;

    assign fin_last = (r_req == REQ_ENCODE) ? i_stat.total_lt16 : i_stat.total_eq8;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_pack  = r_pack;
        n_st    = r_st;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_req   = i_req;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_EMIT;
                n_pack  = 1'b0;
                n_st    = 1'b0;
                case (r_req)
                    REQ_ENCODE: begin
                        n_pack     = i_stat.hit;
                        n_st       = !i_stat.hit;
                        cmd.append = i_stat.hit;
                    end
                    REQ_END: begin
                        n_pack     = 1'b1;
                        n_st       = !i_stat.hit;
                        cmd.append = i_stat.hit;
                    end
                    default: begin
                    end
                endcase
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.push = 1'b1;
                    if (!r_pack) begin
                        cmd.out_status = r_st;
                        cmd.out_last   = 1'b1;
                        n_state        = ST_IDLE;
                    end else if (i_stat.have_byte) begin
                        cmd.out_sel    = 1'b1;
                        cmd.out_bvalid = 1'b1;
                        cmd.out_last   = fin_last;
                        cmd.out_status = fin_last && r_st;
                        cmd.shift      = 1'b1;
                        cmd.clear      = fin_last && (r_req == REQ_END);
                        if (fin_last) begin
                            n_state = ST_IDLE;
                        end
                    end else if (r_req == REQ_END) begin
                        cmd.out_sel    = 1'b1;
                        cmd.out_bvalid = !i_stat.total_zero;
                        cmd.out_status = r_st;
                        cmd.out_last   = 1'b1;
                        cmd.clear      = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        cmd.out_last = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_pack <= n_pack;
        r_st   <= n_st;
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = cmd;

    `HTE_ASSERT(a_push_in_emit, cmd.push |-> (r_state == ST_EMIT), "push outside emit")
    `HTE_ASSERT(a_last_ends, (cmd.push && cmd.out_last) |=> (r_state == ST_IDLE),
                "item not finished after last result")
    `HTE_ASSERT(a_look_once, (r_state == ST_LOOK) |=> (r_state == ST_EMIT),
                "lookup longer than one cycle")

endmodule

### design/huffman_table_encoder_bitpacker.sv
// ---------------------------------------------------------------------------
// huffman_table_encoder_bitpacker
// Table-driven huffman encoder with lsb-first byte packing and an
// end-of-stream code entry.
//
//   channel  dir  tdata                               tuser              tlast
//   s_axis   in   symbol, code_bits, code_len (48b)   req_type           -
//   m_axis   out  out_byte (8b)                       byte_valid,status  last
//
// Each item is accepted, its table entry is read, and then it gives 1 to 5
// results; the table ram read port sets the lookup.
// Results go through a single output register; a stalled m_axis holds the
// emit sequence, and the next item is accepted only after it has ended.
// Synchronous active-low reset clears the length table valid bits and the
// pending byte; no clearing pass is needed.
// ---------------------------------------------------------------------------
module huffman_table_encoder_bitpacker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hte_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // symbol, code_bits, code_len
    input  logic [hte_pkg::IN_USER_W-1:0]  s_axis_tuser,  // req_type
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hte_pkg::BYTE_W-1:0]     m_axis_tdata,  // out_byte
    output logic [hte_pkg::OUT_USER_W-1:0] m_axis_tuser,  // byte_valid, status
    output logic                           m_axis_tlast
);
    import hte_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req      (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hte_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (s_axis_tdata),
        .i_req       (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_byte  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
